[rtl/core/psr_pkg.sv]
// shared types and constants of the pretrigger sample ring
`timescale 1ns / 1ps

package psr_pkg;

    localparam int unsigned SAMPLE_W = 64;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef enum logic
    {
        FUNC_PUSH = 1'b0,
        FUNC_DUMP = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_DUMP = 2'b10
    } state_t;

endpackage

[rtl/core/psr_if.sv]
// valid/ready channel interfaces for commands and dumped samples
`timescale 1ns / 1ps

interface psr_cmd_if;
    logic             valid;
    logic             ready;
    psr_pkg::func_t   func;
    psr_pkg::sample_t sample;

    modport source (output valid, output func, output sample, input ready);
    modport sink (input valid, input func, input sample, output ready);
endinterface

interface psr_res_if;
    logic             valid;
    logic             ready;
    psr_pkg::sample_t sample_out;
    logic             last;

    modport source (output valid, output sample_out, output last, input ready);
    modport sink (input valid, input sample_out, input last, output ready);
endinterface

[rtl/core/psr_ram.sv]
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module psr_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/pretrigger_sample_ring_core.sv]
// pretrigger sample ring: push into a circular store, dump oldest to newest
//
//  channel  dir  fields             transfer
//  cmd      in   func, sample       cmd.valid && cmd.ready
//  result   out  sample_out, last   result.valid && result.ready
//
//  a push leaves cmd.ready high, so pushes go one per cycle while no dump is running
//  a dump of n held samples holds cmd off until the ram read port has walked all n
//  held entries of the ring; each result passes the ram read register, then the output register
//  result stalls back up through the ram read stage to the read sequencer
//  reset clears the counters and pipeline valids; the sample store is not cleared
`timescale 1ns / 1ps

module pretrigger_sample_ring_core #(
    parameter int unsigned RING_DEPTH  = 64,
    parameter int unsigned SAMPLE_BITS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    psr_cmd_if.sink        cmd,
    psr_res_if.source      result
);

    import psr_pkg::*;

    localparam int unsigned PTR_W = $clog2(RING_DEPTH);
    localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
    localparam int unsigned SUM_W = PTR_W + 2;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   wp_reg, wp_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [PTR_W-1:0]   rp_reg, rp_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic               s1_vld_reg, s1_vld_next;
    logic               s1_last_reg, s1_last_next;
    logic               out_vld_reg, out_vld_next;
    logic               out_last_reg;
    sample_t            out_data_reg;

    logic                   cmd_xfer;
    logic                   push;
    logic                   s1_move;
    logic                   rd_en;
    logic [SUM_W-1:0]       start_sum;
    logic [PTR_W-1:0]       start_ptr;
    logic [SAMPLE_BITS-1:0] rd_data;

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign cmd_xfer   = cmd.valid && cmd.ready;
    assign push       = cmd_xfer && (cmd.func == FUNC_PUSH);

    assign s1_move    = s1_vld_reg && (!out_vld_reg || result.ready);
    assign rd_en      = (state_reg == ST_DUMP) && (!s1_vld_reg || s1_move);

    // oldest entry: write position minus fill count, modulo depth
    always_comb
    begin
        start_sum = SUM_W'(wp_reg) + SUM_W'(RING_DEPTH) - SUM_W'(fill_reg);
        if (start_sum >= SUM_W'(RING_DEPTH))
        begin
            start_sum = start_sum - SUM_W'(RING_DEPTH);
        end
        start_ptr = start_sum[PTR_W-1:0];
    end

    psr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (push),
        .wr_addr (wp_reg),
        .wr_data (cmd.sample[SAMPLE_BITS-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rp_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        fill_next    = fill_reg;
        rp_next      = rp_reg;
        left_next    = left_reg;
        s1_last_next = s1_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (push)
                begin
                    wp_next = (wp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                    if (fill_reg < CNT_W'(RING_DEPTH))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
                else if (cmd_xfer && (fill_reg != '0))
                begin
                    state_next = ST_DUMP;
                    rp_next    = start_ptr;
                    left_next  = fill_reg;
                end
            end
            ST_DUMP:
            begin
                if (rd_en)
                begin
                    rp_next      = (rp_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
                    left_next    = left_reg - 1'b1;
                    s1_last_next = (left_reg == CNT_W'(1));
                    if (left_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (rd_en)
        begin
            s1_vld_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (s1_move)
        begin
            out_vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            fill_reg    <= '0;
            rp_reg      <= '0;
            left_reg    <= '0;
            s1_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            fill_reg    <= fill_next;
            rp_reg      <= rp_next;
            left_reg    <= left_next;
            s1_vld_reg  <= s1_vld_next;
            s1_last_reg <= s1_last_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_data_reg <= SAMPLE_W'(rd_data);
            out_last_reg <= s1_last_reg;
        end
    end

    assign result.valid      = out_vld_reg;
    assign result.sample_out = out_data_reg;
    assign result.last       = out_last_reg;

endmodule

[rtl/core/psr_checker.sv]
// port-level checks of the pretrigger sample ring and their bind
`timescale 1ns / 1ps

module psr_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             cmd_valid,
    input logic             cmd_ready,
    input psr_pkg::func_t   cmd_func,
    input logic             res_valid,
    input logic             res_ready,
    input psr_pkg::sample_t res_sample_out,
    input logic             res_last
);

    import psr_pkg::*;

    // stalled result holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_sample_out) && $stable(res_last))
        else $error("stalled result changed");

    // a push never blocks the next command
    a_push_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_func == FUNC_PUSH) |=> cmd_ready)
        else $error("ready dropped after push");

    // commands are held off only after a dump transfer
    a_hold_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(cmd_ready) |-> $past(cmd_valid) && (($past(cmd_func)) == FUNC_DUMP))
        else $error("ready dropped without dump");

    // no result is shown right after reset is seen low
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result valid during reset");

endmodule

bind pretrigger_sample_ring_core psr_checker u_psr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .cmd_func       (cmd.func),
    .res_valid      (result.valid),
    .res_ready      (result.ready),
    .res_sample_out (result.sample_out),
    .res_last       (result.last)
);

[tb/tb_pretrigger_sample_ring_core.sv]
// testbench for the pretrigger sample ring: table-driven and random pushes and dumps
`timescale 1ns / 1ps

module tb_pretrigger_sample_ring_core;

    import psr_pkg::*;

    localparam int unsigned DEPTH = 64;

    typedef struct {
        sample_t sample;
        logic    last;
    } dumped_t;

    typedef struct {
        func_t   func;
        sample_t sample;
        bit      typed;
        int      n_typed;
        sample_t t0;
        sample_t t1;
    } step_t;

    logic clk;
    logic rst_n;

    psr_cmd_if cmd_ch ();
    psr_res_if res_ch ();

    pretrigger_sample_ring_core #(
        .RING_DEPTH  (DEPTH),
        .SAMPLE_BITS (SAMPLE_W)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (res_ch)
    );

    sample_t ring_mem [DEPTH];
    int      wr_pos;
    int      fill_level;
    dumped_t expected_dump [$];

    int errors = 0;
    int results_seen = 0;
    int pushes_sent;
    int dumps_sent;
    int overwrites;
    int burst_left;
    int random_items;
    int hold_reqs = 0;

    step_t dir_steps [12];

    always #5 clk = ~clk;

    function automatic sample_t rand_sample();
        return {$urandom(), $urandom()};
    endfunction

    function automatic void expect_add(sample_t s, logic l);
        dumped_t d;
        d.sample = s;
        d.last = l;
        expected_dump = {expected_dump, d};
    endfunction

    function automatic void ring_apply(func_t f, sample_t s, bit predict);
        int start;
        if (f == FUNC_PUSH)
        begin
            ring_mem[wr_pos] = s;
            wr_pos = (wr_pos + 1) % DEPTH;
            if (fill_level < DEPTH)
                fill_level++;
            else
                overwrites++;
        end
        else if (predict)
        begin
            start = (wr_pos + DEPTH - fill_level) % DEPTH;
            for (int i = 0; i < fill_level; i++)
                expect_add(ring_mem[(start + i) % DEPTH], i == fill_level - 1);
        end
    endfunction

    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("MISMATCH at %0t: %s got %h want %h", $time, what, got, want);
    endtask

    task automatic send_cmd(func_t f, sample_t s);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        cmd_ch.valid  <= 1'b1;
        cmd_ch.func   <= f;
        cmd_ch.sample <= s;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (f == FUNC_PUSH)
            pushes_sent++;
        else
            dumps_sent++;
    endtask

    task automatic issue(func_t f, sample_t s);
        send_cmd(f, s);
        ring_apply(f, s, 1'b1);
        random_items++;
    endtask

    // receiver: own stall pattern plus a long hold on request
    initial
    begin
        int hold_left;
        int hold_taken;
        int cyc;
        hold_left = 0;
        hold_taken = 0;
        cyc = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_reqs != hold_taken)
            begin
                hold_taken = hold_reqs;
                hold_left = 250;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                case ((cyc >> 6) % 4)
                    0: res_ch.ready <= 1'b1;
                    1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: res_ch.ready <= ((cyc % 8) != 0);
                    default: res_ch.ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (expected_dump.size() == 0)
                note_mismatch("unexpected result", res_ch.sample_out, '0);
            else
            begin
                if (res_ch.sample_out !== expected_dump[0].sample)
                    note_mismatch("sample_out", res_ch.sample_out, expected_dump[0].sample);
                if (res_ch.last !== expected_dump[0].last)
                    note_mismatch("last", 64'(res_ch.last), 64'(expected_dump[0].last));
                void'(expected_dump.pop_front());
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("timeout with %0d results outstanding", expected_dump.size());
        $display("tb_pretrigger_sample_ring_core NOT OK");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.func = FUNC_PUSH;
        cmd_ch.sample = '0;
        wr_pos = 0;
        fill_level = 0;
        pushes_sent = 0;
        dumps_sent = 0;
        overwrites = 0;
        burst_left = 0;
        random_items = 0;

        dir_steps = '{
            '{FUNC_DUMP, 64'hDEAD_BEEF_0123_4567, 1'b1, 0, 64'h0, 64'h0},
            '{FUNC_PUSH, 64'h0, 1'b0, 0, 64'h0, 64'h0},
            '{FUNC_PUSH, {64{1'b1}}, 1'b0, 0, 64'h0, 64'h0},
            '{FUNC_DUMP, 64'h0, 1'b1, 2, 64'h0, {64{1'b1}}},
            '{FUNC_DUMP, {64{1'b1}}, 1'b1, 2, 64'h0, {64{1'b1}}},
            '{FUNC_PUSH, 64'h5555_5555_5555_5555, 1'b0, 0, 64'h0, 64'h0},
            '{FUNC_PUSH, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 0, 64'h0, 64'h0},
            '{FUNC_PUSH, 64'h8000_0000_0000_0001, 1'b0, 0, 64'h0, 64'h0},
            '{FUNC_PUSH, 64'h1, 1'b0, 0, 64'h0, 64'h0},
            '{FUNC_DUMP, 64'h0, 1'b0, 0, 64'h0, 64'h0},
            '{FUNC_PUSH, 64'h7FFF_FFFF_FFFF_FFFE, 1'b0, 0, 64'h0, 64'h0},
            '{FUNC_DUMP, {64{1'b1}}, 1'b0, 0, 64'h0, 64'h0}
        };

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_steps[i])
        begin
            send_cmd(dir_steps[i].func, dir_steps[i].sample);
            ring_apply(dir_steps[i].func, dir_steps[i].sample, !dir_steps[i].typed);
            if (dir_steps[i].typed)
                for (int k = 0; k < dir_steps[i].n_typed; k++)
                    expect_add((k == 0) ? dir_steps[i].t0 : dir_steps[i].t1,
                               k == dir_steps[i].n_typed - 1);
        end

        // fill to exactly full, dump, then wrap over the oldest
        while (fill_level < DEPTH)
            issue(FUNC_PUSH, rand_sample());
        issue(FUNC_DUMP, rand_sample());
        issue(FUNC_PUSH, rand_sample());
        issue(FUNC_DUMP, rand_sample());

        // long receiver hold while pushes keep coming behind a full dump
        hold_reqs++;
        issue(FUNC_DUMP, rand_sample());
        repeat (10)
            issue(FUNC_PUSH, rand_sample());

        while (random_items < 108)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                issue(FUNC_DUMP, rand_sample());
                if ($urandom_range(0, 3) == 0)
                    issue(FUNC_DUMP, rand_sample());
            end
            else
                repeat ($urandom_range(1, 12))
                    issue(FUNC_PUSH, rand_sample());
        end

        @(negedge clk);
        cmd_ch.valid <= 1'b0;

        while (expected_dump.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d pushes (%0d overwriting the oldest) and %0d dumps",
                 pushes_sent, overwrites, dumps_sent);
        $display("checked %0d dumped samples, %0d mismatches", results_seen, errors);
        if (errors == 0)
            $display("tb_pretrigger_sample_ring_core OK");
        else
            $display("tb_pretrigger_sample_ring_core NOT OK");
        $finish;
    end

endmodule
